>>> rtl/convex_support_point_table_top_defines.svh
// Assertion macros for the convex support point table.
// Used by the checker module; depends on nothing else.
`ifndef CONVEX_SUPPORT_POINT_TABLE_TOP_DEFINES_SVH
`define CONVEX_SUPPORT_POINT_TABLE_TOP_DEFINES_SVH

// implication checked in the same cycle
`define CSPT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define CSPT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cspt_pkg.sv
// Shared types and constants of the convex support point table.
// No dependencies.
`default_nettype none

package cspt_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned CoordWidthDef  = 16;

  // request codes, code 3 is ignored
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  // what every cell of the ring does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_CMP    = 2'd1,
    CELL_ROTATE = 2'd2,
    CELL_INSERT = 2'd3
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_INS_CMP   = 3'd1,
    ST_INS_WR    = 3'd2,
    ST_QRY_RUN   = 3'd3,
    ST_QRY_DRAIN = 3'd4,
    ST_QRY_DONE  = 3'd5
  } state_e;

endpackage

`default_nettype wire

>>> rtl/cspt_cell.sv
// One vertex cell of the sorted ring: holds a vertex, compares it with a new one,
// shifts from its lower neighbor on insert and from its upper neighbor on rotate.
// Depends on cspt_pkg.
`default_nettype none

module cspt_cell import cspt_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef,
  parameter int unsigned COORD_WIDTH  = CoordWidthDef,
  parameter int unsigned IDX          = 0
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire cell_op_e                           op_i,
  input  wire logic [$clog2(MAX_VERTICES+1)-1:0]  count_i,
  input  wire logic signed [COORD_WIDTH-1:0]      new_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]      new_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]      new_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]      prev_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]      prev_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]      prev_z_i,
  input  wire logic                               prev_gt_i,
  input  wire logic signed [COORD_WIDTH-1:0]      next_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]      next_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]      next_z_i,
  output logic signed [COORD_WIDTH-1:0]           x_o,
  output logic signed [COORD_WIDTH-1:0]           y_o,
  output logic signed [COORD_WIDTH-1:0]           z_o,
  output logic                                    gt_o,
  output logic                                    eq_o
);

  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);

  logic signed [COORD_WIDTH-1:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic gt_q, gt_d, eq_q, eq_d;
  logic in_range, lex_gt, lex_eq;

  // cell holds a live entry
  assign in_range = CntW'(IDX) < count_i;

  // new vertex sorts after / equal to this entry
  assign lex_eq = (new_x_i == x_q) && (new_y_i == y_q) && (new_z_i == z_q);
  assign lex_gt = (new_x_i > x_q) ||
                  ((new_x_i == x_q) && ((new_y_i > y_q) ||
                                        ((new_y_i == y_q) && (new_z_i > z_q))));

  // next cell contents
  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    z_d  = z_q;
    gt_d = gt_q;
    eq_d = eq_q;
    unique case (op_i)
      CELL_HOLD: begin
      end
      CELL_CMP: begin
        gt_d = in_range && lex_gt;
        eq_d = in_range && lex_eq;
      end
      CELL_ROTATE: begin
        x_d = next_x_i;
        y_d = next_y_i;
        z_d = next_z_i;
      end
      CELL_INSERT: begin
        if (!gt_q) begin
          if (prev_gt_i) begin
            x_d = new_x_i;
            y_d = new_y_i;
            z_d = new_z_i;
          end else begin
            x_d = prev_x_i;
            y_d = prev_y_i;
            z_d = prev_z_i;
          end
        end
      end
    endcase
  end

  // vertex storage
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // compare flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      gt_q <= gt_d;
      eq_q <= eq_d;
    end
  end

  assign x_o  = x_q;
  assign y_o  = y_q;
  assign z_o  = z_q;
  assign gt_o = gt_q;
  assign eq_o = eq_q;

endmodule

`default_nettype wire

>>> rtl/cspt_dot.sv
// Two-stage dot product unit fed by the head cell of the ring.
// Stage one registers the three products, stage two their sum. Depends on cspt_pkg.
`default_nettype none

module cspt_dot import cspt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned IDX_WIDTH   = 6
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [IDX_WIDTH-1:0]            idx_i,
  input  wire logic signed [COORD_WIDTH-1:0]   vx_i,
  input  wire logic signed [COORD_WIDTH-1:0]   vy_i,
  input  wire logic signed [COORD_WIDTH-1:0]   vz_i,
  input  wire logic signed [COORD_WIDTH-1:0]   dx_i,
  input  wire logic signed [COORD_WIDTH-1:0]   dy_i,
  input  wire logic signed [COORD_WIDTH-1:0]   dz_i,
  output logic                                 valid_o,
  output logic                                 busy_o,
  output logic [IDX_WIDTH-1:0]                 idx_o,
  output logic signed [COORD_WIDTH-1:0]        x_o,
  output logic signed [COORD_WIDTH-1:0]        y_o,
  output logic signed [COORD_WIDTH-1:0]        z_o,
  output logic signed [2*COORD_WIDTH:0]        dot_o
);

  localparam int unsigned PW = 2 * COORD_WIDTH;

  logic                          v1_q, v2_q;
  logic [IDX_WIDTH-1:0]          idx1_q, idx2_q;
  logic signed [COORD_WIDTH-1:0] x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;
  logic signed [PW-1:0]          px_q, py_q, pz_q;
  logic signed [PW:0]            dot_q, dot_d;

  // sign-extended sum of the products
  assign dot_d = $signed({px_q[PW-1], px_q}) + $signed({py_q[PW-1], py_q}) +
                 $signed({pz_q[PW-1], pz_q});

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // products, then sum, with the vertex carried along
  always_ff @(posedge clk_i) begin
    px_q   <= vx_i * dx_i;
    py_q   <= vy_i * dy_i;
    pz_q   <= vz_i * dz_i;
    idx1_q <= idx_i;
    x1_q   <= vx_i;
    y1_q   <= vy_i;
    z1_q   <= vz_i;
    dot_q  <= dot_d;
    idx2_q <= idx1_q;
    x2_q   <= x1_q;
    y2_q   <= y1_q;
    z2_q   <= z1_q;
  end

  assign valid_o = v2_q;
  assign busy_o  = v1_q | v2_q;
  assign idx_o   = idx2_q;
  assign x_o     = x2_q;
  assign y_o     = y2_q;
  assign z_o     = z2_q;
  assign dot_o   = dot_q;

endmodule

`default_nettype wire

>>> rtl/convex_support_point_table_top.sv
// Top level of the convex support point table: ring of vertex cells, dot unit,
// control sequencer and result register. Depends on cspt_pkg, cspt_cell, cspt_dot.
`default_nettype none

// Vertices sit in a ring of MAX_VERTICES cells in lexicographic (x, y, z) order,
// entry i in cell i; no clearing pass is needed after reset. An input transfer is
// taken only while the sequencer is idle. A clear or an unused code leaves the
// sequencer idle. A load goes through the transfer, a step in which every cell
// compares itself with the new vertex, and a step in which the cells at and above
// the sorted place shift up by one, unless the vertex is already stored or the
// table is full. A query rotates the ring a full turn so that every entry passes
// the head cell, which feeds the single two-stage dot product unit. The unit then
// drains and the output register is loaded with the result; the input is ready
// again in the same cycle in which the result shows. The output register lets the
// next item in while a result waits to be taken; a query that finishes while the
// previous result still waits is held until it goes.
module convex_support_point_table_top import cspt_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef,
  parameter int unsigned COORD_WIDTH  = CoordWidthDef
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic [1:0]                              req_type_i,
  input  wire logic signed [COORD_WIDTH-1:0]           vert_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]           vert_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]           vert_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]           dir_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]           dir_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]           dir_z_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic signed [COORD_WIDTH-1:0]                sup_x_o,
  output logic signed [COORD_WIDTH-1:0]                sup_y_o,
  output logic signed [COORD_WIDTH-1:0]                sup_z_o,
  output logic [$clog2(MAX_VERTICES)-1:0]              sup_index_o,
  output logic signed [2*COORD_WIDTH:0]                best_dot_o,
  output logic [$clog2(MAX_VERTICES+1)-1:0]            stored_count_o,
  output logic                                         table_empty_o,
  output logic                                         overflow_seen_o
);

  localparam int unsigned IdxW = $clog2(MAX_VERTICES);
  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned DW   = 2 * COORD_WIDTH + 1;

  state_e   state_q, state_d;
  cell_op_e cell_op;

  logic            in_xfer, out_xfer, feed_valid, out_load, rot_run;
  logic [CntW-1:0] count_q, count_d, rot_q, rot_d;
  logic            ovf_q, ovf_d;
  logic            dup, full;
  logic [IdxW-1:0] mid_idx;

  logic signed [CW-1:0] vin_x_q, vin_y_q, vin_z_q;
  logic signed [CW-1:0] dir_x_q, dir_y_q, dir_z_q;

  // ring wiring
  logic signed [CW-1:0] cx [MAX_VERTICES];
  logic signed [CW-1:0] cy [MAX_VERTICES];
  logic signed [CW-1:0] cz [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] cgt, ceq;

  // dot unit outputs
  logic                 dv, dbusy;
  logic [IdxW-1:0]      didx;
  logic signed [CW-1:0] dx_v, dy_v, dz_v;
  logic signed [DW-1:0] ddot;

  // running maximum and middle entry
  logic signed [DW-1:0] best_dot_q, best_dot_d, mid_dot_q, mid_dot_d;
  logic [IdxW-1:0]      best_idx_q, best_idx_d;
  logic signed [CW-1:0] best_x_q, best_y_q, best_z_q, best_x_d, best_y_d, best_z_d;
  logic signed [CW-1:0] mid_x_q, mid_y_q, mid_z_q, mid_x_d, mid_y_d, mid_z_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic signed [CW-1:0] sup_x_q, sup_y_q, sup_z_q, sup_x_d, sup_y_d, sup_z_d;
  logic [IdxW-1:0]      sup_idx_q, sup_idx_d;
  logic signed [DW-1:0] sup_dot_q, sup_dot_d;
  logic [CntW-1:0]      sup_cnt_q;
  logic                 sup_empty_q, sup_empty_d, sup_ovf_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;
  assign dup      = |ceq;
  assign full     = count_q == CntW'(MAX_VERTICES);
  assign mid_idx  = IdxW'(count_q >> 1);

  // cell ring
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    localparam int unsigned Prev = (i == 0) ? 0 : i - 1;
    localparam int unsigned Next = (i + 1) % MAX_VERTICES;
    cspt_cell #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_WIDTH (COORD_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (cell_op),
      .count_i  (count_q),
      .new_x_i  (vin_x_q),
      .new_y_i  (vin_y_q),
      .new_z_i  (vin_z_q),
      .prev_x_i (cx[Prev]),
      .prev_y_i (cy[Prev]),
      .prev_z_i (cz[Prev]),
      .prev_gt_i((i == 0) ? 1'b1 : cgt[Prev]),
      .next_x_i (cx[Next]),
      .next_y_i (cy[Next]),
      .next_z_i (cz[Next]),
      .x_o      (cx[i]),
      .y_o      (cy[i]),
      .z_o      (cz[i]),
      .gt_o     (cgt[i]),
      .eq_o     (ceq[i])
    );
  end

  // dot product of the head cell's entry
  cspt_dot #(
    .COORD_WIDTH(COORD_WIDTH),
    .IDX_WIDTH  (IdxW)
  ) u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(feed_valid),
    .idx_i  (rot_q[IdxW-1:0]),
    .vx_i   (cx[0]),
    .vy_i   (cy[0]),
    .vz_i   (cz[0]),
    .dx_i   (dir_x_q),
    .dy_i   (dir_y_q),
    .dz_i   (dir_z_q),
    .valid_o(dv),
    .busy_o (dbusy),
    .idx_o  (didx),
    .x_o    (dx_v),
    .y_o    (dy_v),
    .z_o    (dz_v),
    .dot_o  (ddot)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (req_type_i == REQ_LOAD) begin
            state_d = ST_INS_CMP;
          end else if (req_type_i == REQ_QUERY) begin
            state_d = ST_QRY_RUN;
          end
        end
      end
      ST_INS_CMP:   state_d = ST_INS_WR;
      ST_INS_WR:    state_d = ST_IDLE;
      ST_QRY_RUN: begin
        if (rot_q == CntW'(MAX_VERTICES - 1)) begin
          state_d = ST_QRY_DRAIN;
        end
      end
      ST_QRY_DRAIN: begin
        if (!dbusy) begin
          state_d = ST_QRY_DONE;
        end
      end
      ST_QRY_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    cell_op    = CELL_HOLD;
    rot_run    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:      in_ready_o = 1'b1;
      ST_INS_CMP:   cell_op = CELL_CMP;
      ST_INS_WR:    cell_op = (dup || full) ? CELL_HOLD : CELL_INSERT;
      ST_QRY_RUN: begin
        cell_op = CELL_ROTATE;
        rot_run = 1'b1;
      end
      ST_QRY_DRAIN: begin
      end
      ST_QRY_DONE:  out_load = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
  end

  assign feed_valid = rot_run && (rot_q < count_q);

  // table count, overflow flag and rotation counter
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    rot_d   = rot_q;
    if (in_xfer && (req_type_i == REQ_CLEAR)) begin
      count_d = '0;
    end
    if (in_xfer) begin
      rot_d = '0;
    end else if (rot_run) begin
      rot_d = rot_q + 1'b1;
    end
    if ((state_q == ST_INS_WR) && !dup) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // track the first maximum and the middle entry
  always_comb begin
    best_dot_d = best_dot_q;
    best_idx_d = best_idx_q;
    best_x_d   = best_x_q;
    best_y_d   = best_y_q;
    best_z_d   = best_z_q;
    mid_dot_d  = mid_dot_q;
    mid_x_d    = mid_x_q;
    mid_y_d    = mid_y_q;
    mid_z_d    = mid_z_q;
    if (dv) begin
      if ((didx == '0) || (ddot > best_dot_q)) begin
        best_dot_d = ddot;
        best_idx_d = didx;
        best_x_d   = dx_v;
        best_y_d   = dy_v;
        best_z_d   = dz_v;
      end
      if (didx == mid_idx) begin
        mid_dot_d = ddot;
        mid_x_d   = dx_v;
        mid_y_d   = dy_v;
        mid_z_d   = dz_v;
      end
    end
  end

  // pick the result: zeros for an empty table, else the middle entry if it is maximal, else first maximum
  always_comb begin
    sup_empty_d = count_q == '0;
    if (sup_empty_d) begin
      sup_x_d   = '0;
      sup_y_d   = '0;
      sup_z_d   = '0;
      sup_idx_d = '0;
      sup_dot_d = '0;
    end else if (mid_dot_q == best_dot_q) begin
      sup_x_d   = mid_x_q;
      sup_y_d   = mid_y_q;
      sup_z_d   = mid_z_q;
      sup_idx_d = mid_idx;
      sup_dot_d = mid_dot_q;
    end else begin
      sup_x_d   = best_x_q;
      sup_y_d   = best_y_q;
      sup_z_d   = best_z_q;
      sup_idx_d = best_idx_q;
      sup_dot_d = best_dot_q;
    end
  end

  // result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      rot_q       <= rot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // captured request operands
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      vin_x_q <= vert_x_i;
      vin_y_q <= vert_y_i;
      vin_z_q <= vert_z_i;
      dir_x_q <= dir_x_i;
      dir_y_q <= dir_y_i;
      dir_z_q <= dir_z_i;
    end
  end

  // tracker registers
  always_ff @(posedge clk_i) begin
    best_dot_q <= best_dot_d;
    best_idx_q <= best_idx_d;
    best_x_q   <= best_x_d;
    best_y_q   <= best_y_d;
    best_z_q   <= best_z_d;
    mid_dot_q  <= mid_dot_d;
    mid_x_q    <= mid_x_d;
    mid_y_q    <= mid_y_d;
    mid_z_q    <= mid_z_d;
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sup_x_q     <= sup_x_d;
      sup_y_q     <= sup_y_d;
      sup_z_q     <= sup_z_d;
      sup_idx_q   <= sup_idx_d;
      sup_dot_q   <= sup_dot_d;
      sup_cnt_q   <= count_q;
      sup_empty_q <= sup_empty_d;
      sup_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sup_x_o         = sup_x_q;
  assign sup_y_o         = sup_y_q;
  assign sup_z_o         = sup_z_q;
  assign sup_index_o     = sup_idx_q;
  assign best_dot_o      = sup_dot_q;
  assign stored_count_o  = sup_cnt_q;
  assign table_empty_o   = sup_empty_q;
  assign overflow_seen_o = sup_ovf_q;

endmodule

`default_nettype wire

>>> rtl/cspt_checker.sv
// Port-level checks on the result channel of the convex support point table,
// bound to the top level. Depends on cspt_pkg and the assertion macro header.
`default_nettype none

`include "convex_support_point_table_top_defines.svh"

module cspt_checker import cspt_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef,
  parameter int unsigned COORD_WIDTH  = CoordWidthDef
) (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic [$clog2(MAX_VERTICES)-1:0]    sup_index_i,
  input wire logic signed [2*COORD_WIDTH:0]      best_dot_i,
  input wire logic [$clog2(MAX_VERTICES+1)-1:0]  stored_count_i,
  input wire logic                               table_empty_i,
  input wire logic                               overflow_seen_i
);

  // stalled result holds
  `CSPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(sup_index_i) && $stable(best_dot_i), "result changed while stalled")

  // empty table reports zeros
  `CSPT_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_i && table_empty_i, (stored_count_i == 0) && (sup_index_i == 0) && (best_dot_i == 0), "empty result not zero")

  // chosen index lies inside the table
  `CSPT_ASSERT_NOW(a_index_range, clk_i, rst_ni, out_valid_i && !table_empty_i, (stored_count_i != 0) && (sup_index_i < stored_count_i) && (stored_count_i <= MAX_VERTICES), "index outside table")

  // overflow flag is sticky across results
  `CSPT_ASSERT_NEXT(a_ovf_sticky, clk_i, rst_ni, out_valid_i && out_ready_i && overflow_seen_i, !out_valid_i || overflow_seen_i, "overflow flag dropped")

endmodule

bind convex_support_point_table_top cspt_checker #(
  .MAX_VERTICES(MAX_VERTICES),
  .COORD_WIDTH (COORD_WIDTH)
) u_cspt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sup_index_i    (sup_index_o),
  .best_dot_i     (best_dot_o),
  .stored_count_i (stored_count_o),
  .table_empty_i  (table_empty_o),
  .overflow_seen_i(overflow_seen_o)
);

`default_nettype wire
